>>> rtl/lpd_pkg.sv
// Package for the length-prefix deframer: the queued result type and fixed constants.
// Depends on nothing; every other file of the block imports it.
package lpd_pkg;

    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned HDR_CFG_W       = 3;
    localparam logic [2:0]  HDR_BYTES_RESET = 3'd2;
    localparam logic [2:0]  HDR_BYTES_FALLBACK = 3'd2;
    localparam int unsigned QUEUE_DEPTH     = 4;
    localparam int unsigned QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              frame_end;
    } lpd_item_t;

endpackage

>>> rtl/lpd_in_if.sv
// Byte stream channel into the deframer: valid/ready handshake with one raw byte.
// Depends on lpd_pkg.
interface lpd_in_if
    import lpd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

>>> rtl/lpd_out_if.sv
// Payload channel out of the deframer: valid/ready handshake with a byte and a frame end flag.
// Depends on lpd_pkg.
interface lpd_out_if
    import lpd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] payload_byte;
    logic              frame_end;

    modport source (output valid, output payload_byte, output frame_end, input ready);
    modport sink   (input valid, input payload_byte, input frame_end, output ready);
endinterface

>>> rtl/lpd_front.sv
// Front end of the deframer: header gathering, payload counting and classification of bytes.
// Depends on lpd_pkg and lpd_in_if; pushes payload bytes into the result queue.
module lpd_front
    import lpd_pkg::*;
#(
    parameter int unsigned MAX_HEADER_BYTES = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [HDR_CFG_W-1:0] cfg_data,
    lpd_in_if.sink               in_ch,
    input  logic                 queue_full,
    output logic                 push,
    output lpd_item_t            push_item
);

    localparam int unsigned GATHER_W = 8 * MAX_HEADER_BYTES;
    localparam int unsigned LEFT_W   = (GATHER_W > 31) ? 31 : GATHER_W;
    localparam int unsigned CNT_W    = $clog2(MAX_HEADER_BYTES + 1);
    localparam logic [HDR_CFG_W-1:0] MAX_HDR = HDR_CFG_W'(MAX_HEADER_BYTES);

    logic [HDR_CFG_W-1:0] header_bytes_reg;
    logic                 in_payload_reg, in_payload_next;
    logic [CNT_W-1:0]     header_count_reg, header_count_next;
    logic [GATHER_W-1:0]  length_gather_reg, length_gather_next;
    logic [LEFT_W-1:0]    bytes_left_reg, bytes_left_next;

    logic                 accept;
    logic [HDR_CFG_W-1:0] eff_len;
    logic [CNT_W-1:0]     count_inc;
    logic [GATHER_W-1:0]  gather_inc;
    logic                 header_done;
    logic                 len_negative;
    logic                 len_valid;

    assign in_ch.ready = !queue_full;
    assign accept      = in_ch.valid && in_ch.ready;

    // A zero setting falls back to two bytes (or the maximum if that is smaller), and nothing exceeds the maximum.
    always_comb
    begin
        priority if (header_bytes_reg == '0)
        begin
            eff_len = (HDR_BYTES_FALLBACK < MAX_HDR) ? HDR_BYTES_FALLBACK : MAX_HDR;
        end
        else if (header_bytes_reg > MAX_HDR)
        begin
            eff_len = MAX_HDR;
        end
        else
        begin
            eff_len = header_bytes_reg;
        end
    end

    assign count_inc   = header_count_reg + CNT_W'(1);
    assign gather_inc  = GATHER_W'({length_gather_reg, in_ch.in_byte});
    assign header_done = HDR_CFG_W'(count_inc) >= eff_len;
    // Only a full four-byte header can carry a set sign bit.
    assign len_negative = (GATHER_W == 32) ? gather_inc[GATHER_W-1] : 1'b0;
    assign len_valid    = (gather_inc != '0) && !len_negative;

    always_comb
    begin
        in_payload_next    = in_payload_reg;
        header_count_next  = header_count_reg;
        length_gather_next = length_gather_reg;
        bytes_left_next    = bytes_left_reg;
        push               = 1'b0;
        push_item.payload_byte = in_ch.in_byte;
        push_item.frame_end    = (bytes_left_reg == LEFT_W'(1));
        if (accept)
        begin
            if (in_payload_reg)
            begin
                push            = 1'b1;
                bytes_left_next = bytes_left_reg - LEFT_W'(1);
                if (bytes_left_reg == LEFT_W'(1))
                begin
                    in_payload_next = 1'b0;
                end
            end
            else if (header_done)
            begin
                header_count_next  = '0;
                length_gather_next = '0;
                if (len_valid)
                begin
                    bytes_left_next = gather_inc[LEFT_W-1:0];
                    in_payload_next = 1'b1;
                end
            end
            else
            begin
                header_count_next  = count_inc;
                length_gather_next = gather_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_bytes_reg  <= HDR_BYTES_RESET;
            in_payload_reg    <= 1'b0;
            header_count_reg  <= '0;
            length_gather_reg <= '0;
            bytes_left_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                header_bytes_reg <= cfg_data;
            end
            in_payload_reg    <= in_payload_next;
            header_count_reg  <= header_count_next;
            length_gather_reg <= length_gather_next;
            bytes_left_reg    <= bytes_left_next;
        end
    end

    // A frame in progress always has at least one byte still to come.
    a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        in_payload_reg |-> (bytes_left_reg != '0))
        else $error("payload state with no bytes left");

    // Header bytes never reach the queue.
    a_header_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !in_payload_reg) |-> !push)
        else $error("header byte pushed as payload");

    // A frame end leaves payload state on the next cycle.
    a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_item.frame_end) |=> !in_payload_reg)
        else $error("frame end did not close the frame");

    // The header counter never runs past the longest header.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        HDR_CFG_W'(header_count_reg) < MAX_HDR)
        else $error("header count out of range");

endmodule

>>> rtl/lpd_queue.sv
// Back end of the deframer: a small result queue that drives the payload channel.
// Depends on lpd_pkg and lpd_out_if.
module lpd_queue
    import lpd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  lpd_item_t push_item,
    output logic      full,
    lpd_out_if.source out_ch
);

    lpd_item_t              entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   pop;

    assign full   = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop    = out_ch.valid && out_ch.ready;

    assign out_ch.valid        = (count_reg != '0);
    assign out_ch.payload_byte = entry_reg[rd_ptr_reg].payload_byte;
    assign out_ch.frame_end    = entry_reg[rd_ptr_reg].frame_end;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QUEUE_PTR_W'(1) : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + QUEUE_CNT_W'(1);
            2'b01:   count_next = count_reg - QUEUE_CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into a full queue");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (QUEUE_PTR_W'(count_reg) == QUEUE_PTR_W'(wr_ptr_reg - rd_ptr_reg)))
        else $error("queue pointers disagree with the fill count");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + QUEUE_CNT_W'(1)))
        else $error("fill count did not rise on a lone push");

endmodule

>>> rtl/length_prefix_deframer.sv
// Top level of the length-prefix deframer: splits a byte stream into length-prefixed frames.
// Depends on lpd_pkg, lpd_in_if, lpd_out_if, lpd_front and lpd_queue.
//
// Usage
//   in_ch carries one raw byte per transfer. Each frame starts with a big-endian length
//   header of header_bytes bytes (written through cfg_we/cfg_data while the block is idle;
//   zero acts as two, values above MAX_HEADER_BYTES act as the maximum). The header is
//   followed by that many payload bytes, which leave on out_ch one per transfer, with
//   frame_end set on the last. A header of zero, or negative as a signed 32-bit value,
//   is swallowed and no frame results.
//   Throughput is one byte per cycle on both channels while the queue has room: the header
//   and byte-count update is a single small step in the front end. A payload byte is
//   queued on its input transfer and then leaves on out_ch; header bytes produce nothing.
//   A four-entry queue sits between the front end and out_ch. When the receiver stalls
//   the queue fills and in_ch.ready falls only once all four entries are occupied.
//   Reset sets header_bytes to two, empties the queue and awaits a header.
module length_prefix_deframer
    import lpd_pkg::*;
#(
    parameter int unsigned MAX_HEADER_BYTES = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [HDR_CFG_W-1:0] cfg_data,
    lpd_in_if.sink               in_ch,
    lpd_out_if.source            out_ch
);

    logic      queue_full;
    logic      push;
    lpd_item_t push_item;

    lpd_front #(
        .MAX_HEADER_BYTES(MAX_HEADER_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .in_ch      (in_ch),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    lpd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .out_ch    (out_ch)
    );

endmodule
